// ===== sv/rrsm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsm_pkg
// Types and codes shared by the region registration slot manager.
// ----------------------------------------------------------------------------
package rrsm_pkg;

    localparam logic [1:0] REQ_LOCK   = 2'd0;
    localparam logic [1:0] REQ_UNLOCK = 2'd1;

    localparam logic [3:0] ST_HIT     = 4'd0;
    localparam logic [3:0] ST_FREE    = 4'd1;
    localparam logic [3:0] ST_REREG   = 4'd2;
    localparam logic [3:0] ST_EVICT   = 4'd3;
    localparam logic [3:0] ST_BUSY    = 4'd4;
    localparam logic [3:0] ST_NOSLOT  = 4'd5;
    localparam logic [3:0] ST_UNLOCK  = 4'd6;
    localparam logic [3:0] ST_UNLERR  = 4'd7;
    localparam logic [3:0] ST_QUERY   = 4'd8;

    localparam logic [31:0] AGE_MAX = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        CMD_LOCK,
        CMD_UNLOCK,
        CMD_QUERY
    } cmd_t;

    // classified request handed from the front to the back
    typedef struct packed {
        cmd_t        cmd;
        logic [63:0] base;
        logic [31:0] len;
        logic [31:0] id;
        logic [3:0]  uslot;
    } req_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_APPLY,
        BK_OUT
    } back_state_t;

endpackage

// ===== sv/rrsm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsm_front
// Accepts request items, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module rrsm_front
    import rrsm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  in_type,
    input  logic [63:0] in_base,
    input  logic [31:0] in_len,
    input  logic [31:0] in_id,
    input  logic [3:0]  in_uslot,
    output logic        q_valid,
    input  logic        q_ready,
    output req_t        q_data
);
    // two-entry queue
    req_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    req_t       cls;

    always_comb begin
        cls.base  = in_base;
        cls.len   = in_len;
        cls.id    = in_id;
        cls.uslot = in_uslot;
        priority if (in_type == REQ_LOCK) cls.cmd = CMD_LOCK;
        else if (in_type == REQ_UNLOCK)   cls.cmd = CMD_UNLOCK;
        else                              cls.cmd = CMD_QUERY;
    end

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) mem_reg[wp_reg] <= cls;
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (in_valid && in_ready) wp_reg <= ~wp_reg;
            if (q_valid && q_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'((in_valid && in_ready) ? 1 : 0)
                               - 2'((q_valid && q_ready) ? 1 : 0);
        end
    end
endmodule

// ===== sv/rrsm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrsm_back
// Scans the slot table one slot per cycle for a lock request and applies the request.
// ----------------------------------------------------------------------------
module rrsm_back
    import rrsm_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [30:0] key_base,
    input  logic        q_valid,
    output logic        q_ready,
    input  req_t        q_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  out_status,
    output logic [3:0]  out_slot,
    output logic [31:0] out_key,
    output logic        out_dereg,
    output logic        out_idle,
    output logic        out_full
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    back_state_t state_reg, state_next;
    logic [SLOTS-1:0] locked_reg, assigned_reg;
    logic [31:0] age_mem [SLOTS];
    logic [63:0] base_mem [SLOTS];
    logic [31:0] len_mem [SLOTS];
    logic [31:0] id_mem [SLOTS];
    logic [31:0] age_cnt_reg;

    req_t        req_reg;
    logic [IW:0] i_reg;
    logic        have_free_reg, have_old_reg, match_reg;
    logic [IW-1:0] free_reg, old_reg, match_i_reg;
    logic [31:0] old_age_reg;

    logic [3:0]  st_reg;
    logic [3:0]  sl_reg;
    logic [31:0] key_reg;
    logic        dereg_reg;

    logic [IW-1:0] ci;
    logic          mhit;
    assign ci   = i_reg[IW-1:0];
    assign mhit = assigned_reg[ci] && base_mem[ci] == req_reg.base
                  && len_mem[ci] == req_reg.len;

    assign q_ready    = (state_reg == BK_IDLE);
    assign out_valid  = (state_reg == BK_OUT);
    assign out_status = st_reg;
    assign out_slot   = sl_reg;
    assign out_key    = key_reg;
    assign out_dereg  = dereg_reg;
    assign out_idle   = (locked_reg == '0);
    assign out_full   = (locked_reg == '1);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:  if (q_valid) state_next = (q_data.cmd == CMD_LOCK) ? BK_SCAN : BK_APPLY;
            BK_SCAN:  if (mhit || i_reg == (IW+1)'(SLOTS-1)) state_next = BK_APPLY;
            BK_APPLY: state_next = BK_OUT;
            BK_OUT:   if (out_ready) state_next = BK_IDLE;
            default:  state_next = BK_IDLE;
        endcase
    end

    logic [31:0] age_inc;
    assign age_inc = (age_cnt_reg != AGE_MAX) ? age_cnt_reg + 32'd1 : age_cnt_reg;

    always_ff @(posedge aclk) begin
        logic [IW-1:0] t;
        logic          reg_it;
        reg_it = 1'b0;
        t = '0;
        if (state_reg == BK_IDLE && q_valid) begin
            req_reg <= q_data;
            i_reg <= '0;
            have_free_reg <= 1'b0;
            have_old_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        if (state_reg == BK_SCAN) begin
            if (!locked_reg[ci] && (!have_old_reg || age_mem[ci] < old_age_reg)) begin
                have_old_reg <= 1'b1;
                old_age_reg <= age_mem[ci];
                old_reg <= ci;
            end
            if (!have_free_reg && !locked_reg[ci] && !assigned_reg[ci]) begin
                have_free_reg <= 1'b1;
                free_reg <= ci;
            end
            if (mhit) begin
                match_reg <= 1'b1;
                match_i_reg <= ci;
            end
            i_reg <= i_reg + 1'b1;
        end
        if (state_reg == BK_APPLY) begin
            dereg_reg <= 1'b0;
            sl_reg <= 4'd0;
            key_reg <= 32'd0;
            unique case (req_reg.cmd)
                CMD_LOCK: begin
                    priority if (match_reg) begin
                        t = match_i_reg;
                        if (locked_reg[t]) st_reg <= ST_BUSY;
                        else if (id_mem[t] != req_reg.id) begin
                            st_reg <= ST_REREG; dereg_reg <= 1'b1; reg_it = 1'b1;
                        end else st_reg <= ST_HIT;
                    end else if (have_free_reg) begin
                        t = free_reg; st_reg <= ST_FREE; reg_it = 1'b1;
                    end else if (have_old_reg) begin
                        t = old_reg; st_reg <= ST_EVICT; dereg_reg <= 1'b1; reg_it = 1'b1;
                    end else st_reg <= ST_NOSLOT;
                    if (match_reg || have_free_reg || have_old_reg) begin
                        sl_reg <= 4'(t);
                        key_reg <= {1'b0, key_base} + 32'(t) + 32'd1;
                    end
                    if (reg_it) begin
                        age_mem[t] <= age_inc;
                        base_mem[t] <= req_reg.base;
                        len_mem[t] <= req_reg.len;
                        id_mem[t] <= req_reg.id;
                    end
                end
                CMD_UNLOCK: begin
                    sl_reg <= req_reg.uslot;
                    key_reg <= {1'b0, key_base} + 32'(req_reg.uslot) + 32'd1;
                    if (32'(req_reg.uslot) < SLOTS && locked_reg[IW'(req_reg.uslot)])
                        st_reg <= ST_UNLOCK;
                    else st_reg <= ST_UNLERR;
                end
                default: st_reg <= ST_QUERY;
            endcase
        end

        if (!aresetn) begin
            state_reg <= BK_IDLE;
            locked_reg <= '0;
            assigned_reg <= '0;
            age_cnt_reg <= 32'd0;
            for (int k = 0; k < SLOTS; k++) age_mem[k] <= 32'd0;
        end else begin
            state_reg <= state_next;
            if (state_reg == BK_APPLY) begin
                if (req_reg.cmd == CMD_LOCK && (match_reg || have_free_reg || have_old_reg)
                    && !(match_reg && locked_reg[t]))
                    locked_reg[t] <= 1'b1;
                if (reg_it) begin
                    assigned_reg[t] <= 1'b1;
                    age_cnt_reg <= age_inc;
                end
                if (req_reg.cmd == CMD_UNLOCK && 32'(req_reg.uslot) < SLOTS)
                    locked_reg[IW'(req_reg.uslot)] <= 1'b0;
            end
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && !out_ready |=> out_valid && $stable(out_status))
        else $error("result changed while stalled");
    a_busy_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid && out_status == ST_BUSY |-> $stable(locked_reg))
        else $error("busy changed lock state");
    a_scan_only_lock: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BK_SCAN |-> req_reg.cmd == CMD_LOCK)
        else $error("scan on non-lock request");
endmodule

// ===== sv/region_registration_slot_manager_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_registration_slot_manager_unit
// Slot table for region registrations with lock, unlock and status requests.
// ----------------------------------------------------------------------------
// A lock item scans the slot table one slot per cycle, and the scan stops at
// the first match; unlock and query items skip the scan. The back end takes
// no new item until the result of the last one has been taken.
// A two-entry queue lets new items be taken while the back end works.
// Reset: synchronous active-low aresetn clears locks, assignments, ages,
// the age counter and the key base register.
module region_registration_slot_manager_unit
    import rrsm_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [63:0] s_region_base,
    input  logic [31:0] s_region_len,
    input  logic [31:0] s_region_id,
    input  logic [3:0]  s_unlock_slot,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_status,
    output logic [3:0]  m_slot_index,
    output logic [31:0] m_region_key,
    output logic        m_needs_deregister,
    output logic        m_all_unlocked,
    output logic        m_all_locked
);
    logic [30:0] key_base_reg;
    logic        q_valid, q_ready;
    req_t        q_data;

    // single register: key base at address 0
    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {1'b0, key_base_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) key_base_reg <= '0;
        else if (psel && penable && pwrite && paddr == 2'd0) key_base_reg <= pwdata[30:0];
    end

    rrsm_front u_front (
        .aclk, .aresetn,
        .in_valid(s_valid), .in_ready(s_ready), .in_type(s_req_type),
        .in_base(s_region_base), .in_len(s_region_len), .in_id(s_region_id),
        .in_uslot(s_unlock_slot),
        .q_valid, .q_ready, .q_data
    );

    rrsm_back #(.SLOTS(SLOTS)) u_back (
        .aclk, .aresetn, .key_base(key_base_reg),
        .q_valid, .q_ready, .q_data,
        .out_valid(m_valid), .out_ready(m_ready), .out_status(m_status),
        .out_slot(m_slot_index), .out_key(m_region_key), .out_dereg(m_needs_deregister),
        .out_idle(m_all_unlocked), .out_full(m_all_locked)
    );
endmodule

// ===== test/region_registration_slot_manager_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// region_registration_slot_manager_unit_test
// Self-checking bench for the region registration slot manager: directed and
// random lock, unlock and query items against an in-bench slot table model,
// with random idling on both channels and key base changes between phases.
// ----------------------------------------------------------------------------
module region_registration_slot_manager_unit_test
    import rrsm_pkg::*;
;

    localparam int NSLOT = 16;
    localparam int DRAIN_CYCLES = 40;       // margin for the slot scan plus queue
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic [1:0]  req;
        logic [63:0] base;
        logic [31:0] len;
        logic [31:0] id;
        logic [3:0]  uslot;
    } lock_item_t;

    typedef struct {
        logic [3:0]  status;
        logic [3:0]  slot;
        logic [31:0] key;
        logic        dereg;
        logic        idle;
        logic        full;
    } slot_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = '0;
    logic [63:0] s_region_base = '0;
    logic [31:0] s_region_len = '0;
    logic [31:0] s_region_id = '0;
    logic [3:0]  s_unlock_slot = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_status, m_slot_index;
    logic [31:0] m_region_key;
    logic        m_needs_deregister, m_all_unlocked, m_all_locked;

    region_registration_slot_manager_unit u_top (.*);

    always #5 aclk = ~aclk;

    // ---- slot table model -------------------------------------------------
    logic [30:0] mdl_key_base;
    logic        mdl_locked   [NSLOT];
    logic        mdl_assigned [NSLOT];
    logic [31:0] mdl_age      [NSLOT];
    logic [63:0] mdl_rbase    [NSLOT];
    logic [31:0] mdl_rlen     [NSLOT];
    logic [31:0] mdl_rid      [NSLOT];
    logic [31:0] mdl_age_ctr;

    slot_result_t expected_results[$];
    lock_item_t   pending_items[$];

    function automatic void table_reset();
        mdl_key_base = '0;
        mdl_age_ctr  = '0;
        for (int i = 0; i < NSLOT; i++) begin
            mdl_locked[i] = 0; mdl_assigned[i] = 0; mdl_age[i] = '0;
            mdl_rbase[i] = '0; mdl_rlen[i] = '0; mdl_rid[i] = '0;
        end
    endfunction

    function automatic void claim_slot(int i, lock_item_t it);
        if (mdl_age_ctr != AGE_MAX) mdl_age_ctr++;
        mdl_assigned[i] = 1;
        mdl_age[i]   = mdl_age_ctr;
        mdl_rbase[i] = it.base;
        mdl_rlen[i]  = it.len;
        mdl_rid[i]   = it.id;
        mdl_locked[i] = 1;
    endfunction

    function automatic slot_result_t predict_slot_result(lock_item_t it);
        slot_result_t r;
        bit have_free, have_old, decided, any_l, any_u;
        int free_i, old_i;
        logic [31:0] old_age;
        have_free = 0; have_old = 0; decided = 0; any_l = 0; any_u = 0;
        free_i = 0; old_i = 0; old_age = '0;
        r = '{ST_QUERY, 4'd0, 32'd0, 1'b0, 1'b0, 1'b0};
        if (it.req == REQ_LOCK) begin
            for (int i = 0; i < NSLOT && !decided; i++) begin
                if (!mdl_locked[i] && (!have_old || mdl_age[i] < old_age)) begin
                    have_old = 1; old_age = mdl_age[i]; old_i = i;
                end
                if (!have_free && !mdl_locked[i] && !mdl_assigned[i]) begin
                    have_free = 1; free_i = i;
                end
                if (mdl_assigned[i] && mdl_rbase[i] == it.base
                        && mdl_rlen[i] == it.len) begin
                    decided = 1;
                    r.slot = 4'(i);
                    if (mdl_locked[i]) r.status = ST_BUSY;
                    else if (mdl_rid[i] != it.id) begin
                        r.status = ST_REREG; r.dereg = 1; claim_slot(i, it);
                    end else begin
                        r.status = ST_HIT; mdl_locked[i] = 1;
                    end
                end
            end
            if (!decided) begin
                if (have_free) begin
                    r.status = ST_FREE; r.slot = 4'(free_i); claim_slot(free_i, it);
                end else if (have_old) begin
                    r.status = ST_EVICT; r.slot = 4'(old_i); r.dereg = 1;
                    claim_slot(old_i, it);
                end else r.status = ST_NOSLOT;
            end
            if (r.status != ST_NOSLOT) r.key = {1'b0, mdl_key_base} + r.slot + 1;
        end else if (it.req == REQ_UNLOCK) begin
            r.slot = it.uslot;
            r.key = {1'b0, mdl_key_base} + it.uslot + 1;
            if (mdl_locked[it.uslot]) begin
                mdl_locked[it.uslot] = 0; r.status = ST_UNLOCK;
            end else r.status = ST_UNLERR;
        end
        for (int i = 0; i < NSLOT; i++)
            if (mdl_locked[i]) any_l = 1; else any_u = 1;
        r.idle = !any_l;
        r.full = !any_u;
        return r;
    endfunction

    // ---- driver -----------------------------------------------------------
    int  send_gap = 0;
    bit  send_pause = 0;     // set by the stimulus to let the table drain
    bit  burst_mode = 0;
    int  accepted = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                accepted <= accepted + 1;
                expected_results.push_back(predict_slot_result('{s_req_type,
                    s_region_base, s_region_len, s_region_id, s_unlock_slot}));
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0 || send_pause || pending_items.size() == 0) begin
                    s_valid <= 1'b0;
                    if (send_gap > 0) send_gap <= send_gap - 1;
                end else begin
                    lock_item_t it;
                    it = pending_items.pop_front();
                    s_valid <= 1'b1;
                    s_req_type <= it.req; s_region_base <= it.base;
                    s_region_len <= it.len; s_region_id <= it.id;
                    s_unlock_slot <= it.uslot;
                    send_gap <= burst_mode ? 0 : $urandom_range(0, 10);
                end
            end
        end
    end

    // ---- long receiver stall, counted in its own process ------------------
    bit  stall_req = 0;      // raised once by the stimulus
    bit  stall_done = 0;
    int  hold_off = 0;
    always @(posedge aclk) begin
        if (stall_req && !stall_done) begin
            stall_done <= 1'b1;
            hold_off <= 300;
        end else if (hold_off > 0) hold_off <= hold_off - 1;
    end

    // ---- monitor / receiver -----------------------------------------------
    int  recv_gap = 0;
    int  mismatches = 0, results_seen = 0;
    int  status_hits[9];
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                slot_result_t e;
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected result status=%0d", m_status);
                end else begin
                    e = expected_results.pop_front();
                    if (m_status <= ST_QUERY) status_hits[m_status]++;
                    if (m_status !== e.status || m_slot_index !== e.slot
                            || m_region_key !== e.key || m_needs_deregister !== e.dereg
                            || m_all_unlocked !== e.idle || m_all_locked !== e.full) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: exp st=%0d sl=%0d key=%h dr=%b id=%b fu=%b / act st=%0d sl=%0d key=%h dr=%b id=%b fu=%b",
                                e.status, e.slot, e.key, e.dereg, e.idle, e.full,
                                m_status, m_slot_index, m_region_key,
                                m_needs_deregister, m_all_unlocked, m_all_locked);
                    end
                end
            end
            if (hold_off > 0) begin
                m_ready <= 1'b0;
            end else if (!m_ready || m_valid) begin
                if (recv_gap > 0) begin
                    recv_gap <= recv_gap - 1;
                    m_ready <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                    if (m_valid) recv_gap <= burst_mode ? 0 : $urandom_range(0, 10);
                end
            end
        end
    end

    // ---- configuration writes (only while idle) ---------------------------
    task automatic write_key_base(logic [30:0] v);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 2'd0; pwdata <= {1'b0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        mdl_key_base = v;
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // region pool so locks keep colliding on base/length
    logic [63:0] pool_base[24];
    logic [31:0] pool_len[24];

    function automatic lock_item_t random_item();
        lock_item_t it;
        int k, r;
        r = $urandom_range(0, 99);
        k = $urandom_range(0, 23);
        it.base = pool_base[k];
        it.len = pool_len[k];
        it.id = $urandom_range(0, 2);
        it.uslot = 4'($urandom_range(0, 15));
        if (r < 55) it.req = REQ_LOCK;
        else if (r < 90) it.req = REQ_UNLOCK;
        else it.req = 2'($urandom_range(2, 3));
        if ($urandom_range(0, 9) == 0) begin
            it.base = {$urandom, $urandom};
            it.len = $urandom;
            it.id = $urandom;
        end
        return it;
    endfunction

    function automatic void add_item(logic [1:0] rq, logic [63:0] b, logic [31:0] l,
                                     logic [31:0] id, logic [3:0] us);
        pending_items.push_back('{rq, b, l, id, us});
    endfunction

    longint cycles = 0;
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int acc0;
        table_reset();
        for (int i = 0; i < 24; i++) begin
            pool_base[i] = {$urandom, $urandom} | 64'd1;
            pool_len[i] = $urandom_range(1, 4) * 32'h1000;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: field extremes, every request type, busy, hit, rereg
        write_key_base(31'h7FFF_FFFF);                    // largest key base
        add_item(REQ_LOCK, 64'd1, 32'd1, 32'd0, 4'd0);    // free slot
        add_item(REQ_LOCK, 64'd1, 32'd1, 32'd5, 4'd0);    // busy
        add_item(REQ_UNLOCK, '0, '0, '0, 4'd0);
        add_item(REQ_LOCK, 64'd1, 32'd1, 32'd0, 4'd0);    // hit
        add_item(REQ_UNLOCK, '0, '0, '0, 4'd0);
        add_item(REQ_LOCK, 64'd1, 32'd1, 32'hFFFF_FFFF, 4'd0); // reregistered
        add_item(REQ_UNLOCK, '0, '0, '0, 4'd15);          // unlock error
        add_item(2'd2, '1, '1, '1, 4'd15);                // query
        add_item(2'd3, '1, '1, '1, 4'd15);                // unused type
        add_item(REQ_LOCK, '0, '0, '0, 4'd0);             // zero base/len never hits empty
        wait_drained();
        write_key_base(31'd0);
        // fill every slot, then no slot, then evict oldest
        for (int i = 0; i < 15; i++)
            add_item(REQ_LOCK, 64'hFFFF_FFFF_FFFF_FF00 + i, 32'hFFFF_FFFF, i, 4'd0);
        add_item(REQ_LOCK, 64'h55, 32'h10, 32'd1, 4'd0);   // no slot
        add_item(REQ_UNLOCK, '0, '0, '0, 4'd7);
        add_item(REQ_UNLOCK, '0, '0, '0, 4'd3);
        add_item(REQ_LOCK, 64'h55, 32'h10, 32'd1, 4'd0);   // evict oldest
        wait_drained();

        // random phases with key base changes between them
        for (int ph = 0; ph < 6; ph++) begin
            write_key_base(ph == 5 ? 31'h7FFF_FFF0 : 31'($urandom));
            if (ph == 2) begin
                // long receiver stall while sender keeps offering
                stall_req = 1'b1;
            end
            burst_mode = (ph == 3);
            acc0 = accepted;
            for (int n = 0; n < 190; n++) pending_items.push_back(random_item());
            if (ph == 4) begin
                // sender pause mid-phase until every expected result is back
                while (accepted < acc0 + 95) @(posedge aclk);
                send_pause = 1'b1;
                while (s_valid || expected_results.size() != 0) @(posedge aclk);
                send_pause = 1'b0;
            end
            wait_drained();
        end

        $display("covered %0d items, %0d results; status counts hit..query:", accepted,
                 results_seen);
        $display("  %0d %0d %0d %0d %0d %0d %0d %0d %0d", status_hits[0], status_hits[1],
                 status_hits[2], status_hits[3], status_hits[4], status_hits[5],
                 status_hits[6], status_hits[7], status_hits[8]);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
